FILE: rtl/segment_intersection_test_top_defines.svh
// Assertion macros for the segment intersection test block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH

// same-cycle implication
`define SIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sit_pkg.sv
// Shared types and constants for the segment intersection test block.
// No dependencies.
`default_nettype none

package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int TOL_W      = 35;
  localparam int CMPD_W     = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;
  localparam int CMPX_W     = (CROSS_W > TOL_W) ? CROSS_W : TOL_W;
  localparam int N_ORI      = 4;

  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  typedef enum logic [1:0] {
    ORI_COLL = 2'd0,
    ORI_CW   = 2'd1,
    ORI_CCW  = 2'd2
  } orient_t;

  // One request after the front end: cross product operands and
  // bounding-box offsets for the four orientation tests.
  typedef struct packed {
    logic               func;
    diff_t [N_ORI-1:0]  ux;
    diff_t [N_ORI-1:0]  uy;
    diff_t [N_ORI-1:0]  vx;
    diff_t [N_ORI-1:0]  vy;
    diff_t [N_ORI-1:0]  dhx;  // point x minus box high x
    diff_t [N_ORI-1:0]  dlx;  // point x minus box low x
    diff_t [N_ORI-1:0]  dhy;
    diff_t [N_ORI-1:0]  dly;
  } front_t;

endpackage

`default_nettype wire

FILE: rtl/segment_intersection_test_top.sv
// Segment intersection test, top level. Depends on sit_pkg, sit_front, sit_queue, sit_back.
// Throughput: one segment pair per cycle while out_ready does not stall the back end; a request
//   passes the front register, a queue slot, then the product, cross, orientation and output stages.
// A stall on out_ready freezes the back end; the front keeps filling the 4-entry queue.
// Reset (rst_n low, synchronous): all pipeline and queue valids clear, tolerance = 1.
`default_nettype none

module segment_intersection_test_top import sit_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  coord_t           in_a_start_x,
  input  coord_t           in_a_start_y,
  input  coord_t           in_a_end_x,
  input  coord_t           in_a_end_y,
  input  coord_t           in_b_start_x,
  input  coord_t           in_b_start_y,
  input  coord_t           in_b_end_x,
  input  coord_t           in_b_end_y,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  // tolerance register
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  // Tolerance is used both for cross product zero tests and for the
  // coordinate compares of the bounding-box check. Zero means exact
  // compares never count as equal.
  logic [TOL_W-1:0] tol_r;

  logic   f_valid;
  logic   f_ready;
  front_t f_data;
  logic   b_valid;
  logic   b_ready;
  front_t b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Front: register the request, form orientation operands and box offsets.
  sit_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_a_start_x (in_a_start_x),
    .in_a_start_y (in_a_start_y),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_y   (in_a_end_y),
    .in_b_start_x (in_b_start_x),
    .in_b_start_y (in_b_start_y),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_y   (in_b_end_y),
    .f_valid      (f_valid),
    .f_ready      (f_ready),
    .f_data       (f_data)
  );

  // Decoupling queue so front and back stall independently.
  sit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Back: 8 products per pair, cross products, tolerance compares, decision.
  // Strict crossing mode reuses the orientation cross products for the
  // exact on-line tests (same determinant up to sign).
  sit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

endmodule

`default_nettype wire

FILE: rtl/sit_front.sv
// Front end: accepts a request and forms cross product operands and box offsets.
// Depends on sit_pkg.
`default_nettype none

module sit_front import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_func,
  input  coord_t in_a_start_x,
  input  coord_t in_a_start_y,
  input  coord_t in_a_end_x,
  input  coord_t in_a_end_y,
  input  coord_t in_b_start_x,
  input  coord_t in_b_start_y,
  input  coord_t in_b_end_x,
  input  coord_t in_b_end_y,
  output logic   f_valid,
  input  logic   f_ready,
  output front_t f_data
);

  logic   fv_r;
  front_t fd_r;
  front_t fd_nxt;

  assign in_ready = !fv_r || f_ready;
  assign f_valid  = fv_r;
  assign f_data   = fd_r;

  // orient(p, q, r) for tests 0..3: (a,b,c) (a,b,d) (c,d,a) (c,d,b);
  // box check k tests r against the box of p and q
  always_comb begin
    coord_t px [N_ORI];
    coord_t py [N_ORI];
    coord_t qx [N_ORI];
    coord_t qy [N_ORI];
    coord_t rx [N_ORI];
    coord_t ry [N_ORI];
    coord_t hx, lx, hy, ly;
    px[0] = in_a_start_x; py[0] = in_a_start_y;
    qx[0] = in_a_end_x;   qy[0] = in_a_end_y;
    rx[0] = in_b_start_x; ry[0] = in_b_start_y;
    px[1] = in_a_start_x; py[1] = in_a_start_y;
    qx[1] = in_a_end_x;   qy[1] = in_a_end_y;
    rx[1] = in_b_end_x;   ry[1] = in_b_end_y;
    px[2] = in_b_start_x; py[2] = in_b_start_y;
    qx[2] = in_b_end_x;   qy[2] = in_b_end_y;
    rx[2] = in_a_start_x; ry[2] = in_a_start_y;
    px[3] = in_b_start_x; py[3] = in_b_start_y;
    qx[3] = in_b_end_x;   qy[3] = in_b_end_y;
    rx[3] = in_a_end_x;   ry[3] = in_a_end_y;
    fd_nxt      = '0;
    fd_nxt.func = in_func;
    for (int k = 0; k < N_ORI; k++) begin
      fd_nxt.ux[k] = DIFF_W'(rx[k]) - DIFF_W'(qx[k]);
      fd_nxt.uy[k] = DIFF_W'(ry[k]) - DIFF_W'(qy[k]);
      fd_nxt.vx[k] = DIFF_W'(qx[k]) - DIFF_W'(px[k]);
      fd_nxt.vy[k] = DIFF_W'(qy[k]) - DIFF_W'(py[k]);
      hx = (px[k] > qx[k]) ? px[k] : qx[k];
      lx = (px[k] < qx[k]) ? px[k] : qx[k];
      hy = (py[k] > qy[k]) ? py[k] : qy[k];
      ly = (py[k] < qy[k]) ? py[k] : qy[k];
      fd_nxt.dhx[k] = DIFF_W'(rx[k]) - DIFF_W'(hx);
      fd_nxt.dlx[k] = DIFF_W'(rx[k]) - DIFF_W'(lx);
      fd_nxt.dhy[k] = DIFF_W'(ry[k]) - DIFF_W'(hy);
      fd_nxt.dly[k] = DIFF_W'(ry[k]) - DIFF_W'(ly);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fd_r <= fd_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sit_queue.sv
// Short request queue between front end and back end.
// Depends on sit_pkg and the assertion macro header.
`default_nettype none
`include "segment_intersection_test_top_defines.svh"

module sit_queue import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  front_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output front_t pop_data
);

  front_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  `SIT_ASSERT_IMP(a_q_cnt_bound, 1'b1, cnt_r <= Q_CW'(Q_DEPTH), "queue count above depth")
  `SIT_ASSERT_NXT(a_q_cnt_up, push && !pop, cnt_r == $past(cnt_r) + Q_CW'(1), "queue count lost a push")
  `SIT_ASSERT_NXT(a_q_cnt_dn, pop && !push, cnt_r == $past(cnt_r) - Q_CW'(1), "queue count lost a pop")

endmodule

`default_nettype wire

FILE: rtl/sit_back.sv
// Back end: products, cross products, tolerance compares and the final decision.
// Depends on sit_pkg and the assertion macro header.
`default_nettype none
`include "segment_intersection_test_top_defines.svh"

module sit_back import sit_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] tolerance,
  input  logic             q_valid,
  output logic             q_ready,
  input  front_t           q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit
);

  logic adv;

  // stage 1: products and box flags
  logic                     v1_r;
  logic                     func1_r;
  logic signed [PROD_W-1:0] pa_r [N_ORI];
  logic signed [PROD_W-1:0] pb_r [N_ORI];
  logic [N_ORI-1:0]         box1_r;
  logic [N_ORI-1:0]         box_nxt;

  // stage 2: cross products
  logic                      v2_r;
  logic                      func2_r;
  logic signed [CROSS_W-1:0] cr_r [N_ORI];
  logic [N_ORI-1:0]          box2_r;

  // stage 3: orientations
  logic             v3_r;
  logic             func3_r;
  orient_t          ori3_r [N_ORI];
  logic [N_ORI-1:0] zero3_r;
  logic [N_ORI-1:0] box3_r;
  orient_t          ori_nxt [N_ORI];
  logic [N_ORI-1:0] zero_nxt;

  // output
  logic out_valid_r;
  logic hit_r;
  logic hit_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;

  function automatic logic near_d(input diff_t d, input logic [TOL_W-1:0] tol);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return CMPD_W'(m) < CMPD_W'(tol);
  endfunction

  // le_x/le_y: near or below the high edge; ge_x/ge_y: near or above the low edge
  always_comb begin
    diff_t dhx, dlx, dhy, dly;
    logic  le_x, ge_x, le_y, ge_y;
    for (int k = 0; k < N_ORI; k++) begin
      dhx  = $signed(q_data.dhx[k]);
      dlx  = $signed(q_data.dlx[k]);
      dhy  = $signed(q_data.dhy[k]);
      dly  = $signed(q_data.dly[k]);
      le_x = near_d(dhx, tolerance) || dhx[DIFF_W-1];
      ge_x = near_d(dlx, tolerance) || (!dlx[DIFF_W-1] && (dlx != '0));
      le_y = near_d(dhy, tolerance) || dhy[DIFF_W-1];
      ge_y = near_d(dly, tolerance) || (!dly[DIFF_W-1] && (dly != '0));
      box_nxt[k] = le_x && ge_x && le_y && ge_y;
    end
  end

  always_comb begin
    logic [CROSS_W-1:0] mag;
    logic               near;
    for (int k = 0; k < N_ORI; k++) begin
      mag  = cr_r[k][CROSS_W-1] ? CROSS_W'(-cr_r[k]) : CROSS_W'(cr_r[k]);
      near = CMPX_W'(mag) < CMPX_W'(tolerance);
      zero_nxt[k] = (cr_r[k] == '0);
      if (near) begin
        ori_nxt[k] = ORI_COLL;
      end else if (!cr_r[k][CROSS_W-1] && !zero_nxt[k]) begin
        ori_nxt[k] = ORI_CW;
      end else begin
        ori_nxt[k] = ORI_CCW;
      end
    end
  end

  // strict mode rejects any endpoint exactly on the other line
  always_comb begin
    logic gen, coll_hit;
    gen      = (ori3_r[0] != ori3_r[1]) && (ori3_r[2] != ori3_r[3]);
    coll_hit = 1'b0;
    for (int k = 0; k < N_ORI; k++) begin
      coll_hit = coll_hit || ((ori3_r[k] == ORI_COLL) && box3_r[k]);
    end
    hit_nxt = (func3_r && (zero3_r != '0)) ? 1'b0 : (gen || coll_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= q_data.func;
      box1_r  <= box_nxt;
      func2_r <= func1_r;
      box2_r  <= box1_r;
      func3_r <= func2_r;
      box3_r  <= box2_r;
      zero3_r <= zero_nxt;
      hit_r   <= hit_nxt;
      for (int k = 0; k < N_ORI; k++) begin
        pa_r[k]   <= $signed(q_data.ux[k]) * $signed(q_data.vy[k]);
        pb_r[k]   <= $signed(q_data.uy[k]) * $signed(q_data.vx[k]);
        cr_r[k]   <= CROSS_W'(pa_r[k]) - CROSS_W'(pb_r[k]);
        ori3_r[k] <= ori_nxt[k];
      end
    end
  end

  `SIT_ASSERT_NXT(a_b_hold, out_valid_r && !out_ready, out_valid_r && (hit_r == $past(hit_r)) && (v3_r == $past(v3_r)), "stalled result or pipeline changed")
  `SIT_ASSERT_NXT(a_b_flow, v3_r && adv, out_valid_r, "stage 3 request not moved to output")
  `SIT_ASSERT_NXT(a_b_strict, v3_r && adv && func3_r && (zero3_r != '0), !hit_r, "strict mode hit with endpoint on line")

endmodule

`default_nettype wire

FILE: test/tb_segment_intersection_test_top.sv
// Testbench for segment_intersection_test_top: random and directed segment pairs
// checked against a local predictor. Depends on sit_pkg and the block's RTL only.
module tb_segment_intersection_test_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sit_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int PHASE_PAIRS   = 155;  // random requests per tolerance setting
  localparam int DRAIN_CYCLES  = 8;    // extra settling time after the last result
  localparam int N_TOL_PHASES  = 9;

  // One request as it goes onto the input ports.
  typedef struct {
    bit     func;
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Everything starts at a known value.
  // ---------------------------------------------------------------------------
  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             in_func      = 1'b0;
  coord_t           in_a_start_x = '0;
  coord_t           in_a_start_y = '0;
  coord_t           in_a_end_x   = '0;
  coord_t           in_a_end_y   = '0;
  coord_t           in_b_start_x = '0;
  coord_t           in_b_start_y = '0;
  coord_t           in_b_end_x   = '0;
  coord_t           in_b_end_y   = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic             out_hit;
  logic             cfg_we       = 1'b0;
  logic [TOL_W-1:0] cfg_wdata    = '0;

  always #10 clk = ~clk;

  segment_intersection_test_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_a_start_x (in_a_start_x),
    .in_a_start_y (in_a_start_y),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_y   (in_a_end_y),
    .in_b_start_x (in_b_start_x),
    .in_b_start_y (in_b_start_y),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_y   (in_b_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  seg_pair_t        pending_pairs[$];   // requests not yet on the ports
  bit               expected_hits[$];   // predicted answers, oldest first
  seg_pair_t        live_pair;          // request currently on the ports
  logic [TOL_W-1:0] tol_setting = TOL_RESET;  // our copy of the tolerance register
  int               mismatch_count = 0;
  int               result_count   = 0;
  int               cycle_count    = 0;
  bit               req_taken  = 1'b0;  // set at the accepting edge, consumed by the driver
  bit               res_taken  = 1'b0;
  int               send_wait  = 0;
  int               stall_left = 0;
  bit               send_burst = 1'b0;  // burst mode: no gaps between requests
  bit               recv_burst = 1'b0;  // burst mode: out_ready held high

  // ---------------------------------------------------------------------------
  // Predictor. Coordinates are at most 16 bits, so every difference, product and
  // cross product fits comfortably in a longint; nothing can wrap.
  // ---------------------------------------------------------------------------
  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Two values count as equal when they differ by less than the tolerance.
  // A zero tolerance makes nothing equal.
  function automatic bit near_equal(longint a, longint b, longint tol);
    return magnitude(a - b) < tol;
  endfunction

  // Turn direction of p -> q -> r; a small cross product reads as collinear.
  function automatic orient_t orientation(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry, longint tol);
    longint v;
    v = (rx - qx) * (qy - py) - (ry - qy) * (qx - px);
    if (magnitude(v) < tol)
      return ORI_COLL;
    return (v > 0) ? ORI_CW : ORI_CCW;
  endfunction

  // q inside the box spanned by p and r, edges widened by the tolerance
  function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry, longint tol);
    longint hx, lx, hy, ly;
    hx = (px > rx) ? px : rx;
    lx = (px < rx) ? px : rx;
    hy = (py > ry) ? py : ry;
    ly = (py < ry) ? py : ry;
    return (near_equal(qx, hx, tol) || qx < hx) && (near_equal(qx, lx, tol) || qx > lx) &&
           (near_equal(qy, hy, tol) || qy < hy) && (near_equal(qy, ly, tol) || qy > ly);
  endfunction

  // z exactly on the infinite line through p and q (no tolerance)
  function automatic bit on_infinite_line(longint zx, longint zy, longint px, longint py,
                                          longint qx, longint qy);
    return ((qx - px) * (zy - py) - (qy - py) * (zx - px)) == 0;
  endfunction

  function automatic bit predict_hit(seg_pair_t p, longint tol);
    longint  ax, ay, bx, by, cx, cy, dx, dy;
    orient_t o1, o2, o3, o4;
    ax = p.a_start_x;  ay = p.a_start_y;
    bx = p.a_end_x;    by = p.a_end_y;
    cx = p.b_start_x;  cy = p.b_start_y;
    dx = p.b_end_x;    dy = p.b_end_y;
    // strict crossing: any endpoint on the other line rules it out
    if (p.func && (on_infinite_line(ax, ay, cx, cy, dx, dy) ||
                   on_infinite_line(bx, by, cx, cy, dx, dy) ||
                   on_infinite_line(cx, cy, ax, ay, bx, by) ||
                   on_infinite_line(dx, dy, ax, ay, bx, by)))
      return 1'b0;
    o1 = orientation(ax, ay, bx, by, cx, cy, tol);
    o2 = orientation(ax, ay, bx, by, dx, dy, tol);
    o3 = orientation(cx, cy, dx, dy, ax, ay, tol);
    o4 = orientation(cx, cy, dx, dy, bx, by, tol);
    return (o1 != o2 && o3 != o4) ||
           (o1 == ORI_COLL && in_box(ax, ay, cx, cy, bx, by, tol)) ||
           (o2 == ORI_COLL && in_box(ax, ay, dx, dy, bx, by, tol)) ||
           (o3 == ORI_COLL && in_box(cx, cy, ax, ay, dx, dy, tol)) ||
           (o4 == ORI_COLL && in_box(cx, cy, bx, by, dx, dy, tol));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic void queue_pair(bit f, int ax, int ay, int bx, int by,
                                     int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.func      = f;
    p.a_start_x = coord_t'(ax);  p.a_start_y = coord_t'(ay);
    p.a_end_x   = coord_t'(bx);  p.a_end_y   = coord_t'(by);
    p.b_start_x = coord_t'(cx);  p.b_start_y = coord_t'(cy);
    p.b_end_x   = coord_t'(dx);  p.b_end_y   = coord_t'(dy);
    pending_pairs.push_back(p);
  endfunction

  // Random request. Most shapes are built to land on the interesting cases:
  // collinear runs, shared endpoints, T junctions, near-collinear points and
  // degenerate segments; the rest is raw noise over the full coordinate range.
  // Points are kept in c[] as a_start, a_end, b_start, b_end (x, y each).
  function automatic void queue_random_pair();
    int c[8];
    int ox, oy, sx, sy, n, m;
    ox = spread(16000);
    oy = spread(16000);
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[i]) c[i] = int'($urandom_range(0, 65535)) - 32768;
      end
      2: begin
        // corner values of the coordinate range
        foreach (c[i]) begin
          case ($urandom_range(0, 6))
            0: c[i] = -32768;
            1: c[i] = -32767;
            2: c[i] = -1;
            3: c[i] = 0;
            4: c[i] = 1;
            5: c[i] = 32766;
            default: c[i] = 32767;
          endcase
        end
      end
      3, 4: begin
        // tiny cluster: lots of touching, collinear and repeated points
        foreach (c[i]) c[i] = spread(6) + ((i % 2) ? oy : ox);
      end
      5, 6: begin
        // four points on one line (a zero direction gives degenerate segments)
        sx = spread(3);
        sy = spread(3);
        for (int j = 0; j < 4; j++) begin
          n = $urandom_range(0, 1) ? spread(5000) : spread(6);
          c[2*j]   = ox + n * sx;
          c[2*j+1] = oy + n * sy;
        end
      end
      7: begin
        // second segment starts on, next to, or at an end of the first
        sx = spread(50);
        sy = spread(50);
        n  = $urandom_range(1, 40);
        m  = int'($urandom_range(0, n + 4)) - 2;
        c[0] = ox;           c[1] = oy;
        c[2] = ox + n * sx;  c[3] = oy + n * sy;
        c[4] = ox + m * sx;  c[5] = oy + m * sy;
        c[6] = c[4] + spread(200);
        c[7] = c[5] + spread(200);
      end
      8: begin
        // collinear, then one coordinate nudged: cross products near the tolerance
        sx = spread(40);
        sy = spread(40);
        for (int j = 0; j < 4; j++) begin
          n = spread(300);
          c[2*j]   = ox + n * sx;
          c[2*j+1] = oy + n * sy;
        end
        n    = $urandom_range(0, 7);
        c[n] = c[n] + spread(64);
      end
      default: begin
        // general position around a common center
        ox = spread(30000);
        oy = spread(30000);
        foreach (c[i]) c[i] = spread(2000) + ((i % 2) ? oy : ox);
      end
    endcase
    queue_pair($urandom_range(0, 1), c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, result_count, msg);
    mismatch_count++;
  endtask

  // Wait until nothing is queued, on the ports or in flight, then let the
  // pipeline settle. Checked on the rising edge, where the ports are stable.
  task automatic drain_requests();
    while (pending_pairs.size() != 0 || in_valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    tol_setting = value;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: runs on the falling edge. A new request is presented only
  // once the previous one was taken; the gap before each one is drawn at random,
  // with occasional bursts that have no gaps at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      req_taken = 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        live_pair    = pending_pairs.pop_front();
        in_func      <= live_pair.func;
        in_a_start_x <= live_pair.a_start_x;
        in_a_start_y <= live_pair.a_start_y;
        in_a_end_x   <= live_pair.a_end_x;
        in_a_end_y   <= live_pair.a_end_y;
        in_b_start_x <= live_pair.b_start_x;
        in_b_start_y <= live_pair.b_start_y;
        in_b_end_x   <= live_pair.b_end_x;
        in_b_end_y   <= live_pair.b_end_y;
        in_valid     <= 1'b1;
        if ($urandom_range(0, 39) == 0)
          send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: after each result, out_ready drops for a random
  // number of cycles (none while in burst mode).
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      res_taken  = 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 39) == 0)
          recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, predict every accepted request and check every
  // accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_hits.push_back(predict_hit(live_pair, longint'(tol_setting)));
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        res_taken = 1'b1;
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("hit=%0b with no request outstanding", out_hit));
        end else begin
          bit want_hit;
          want_hit = expected_hits.pop_front();
          if (out_hit !== want_hit)
            report_mismatch($sformatf("hit=%b, predicted %0b (tolerance %0d)",
                                      out_hit, want_hit, tol_setting));
        end
        result_count++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** segment_intersection_test_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Phase 0 runs at the reset tolerance with the directed cases;
  // every later phase writes a new tolerance while the block is idle and then
  // sends a batch of random requests. Draining between phases also pauses the
  // sender until every outstanding result is back.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [TOL_W-1:0] tol_plan[N_TOL_PHASES];
    tol_plan[0] = TOL_RESET;                  // left at its reset value
    tol_plan[1] = '0;                         // zero: nothing collinear, box edges exclusive
    tol_plan[2] = TOL_W'(2);
    tol_plan[3] = TOL_W'($urandom_range(3, 1000));
    tol_plan[4] = 35'h4_0000_0000;            // only the top bit of the 35 set
    tol_plan[5] = 35'h7_FFFF_FFFF;            // all 35 bits set
    tol_plan[6] = TOL_W'($urandom_range(1, 1 << 20));
    tol_plan[7] = {3'($urandom_range(0, 7)), 32'($urandom)};
    tol_plan[8] = TOL_W'(1);                  // back to the reset value by a write

    rst_n <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases, several of them in both modes.
    // plain X crossing
    queue_pair(0, 0, 0, 10, 10, 0, 10, 10, 0);
    queue_pair(1, 0, 0, 10, 10, 0, 10, 10, 0);
    // parallel, apart
    queue_pair(0, 0, 0, 10, 0, 0, 5, 10, 5);
    // collinear overlap: intersects, never crosses
    queue_pair(0, 0, 0, 10, 0, 5, 0, 15, 0);
    queue_pair(1, 0, 0, 10, 0, 5, 0, 15, 0);
    // collinear with a gap
    queue_pair(0, 0, 0, 4, 0, 6, 0, 9, 0);
    // shared endpoint
    queue_pair(0, 0, 0, 5, 5, 5, 5, 10, 0);
    queue_pair(1, 0, 0, 5, 5, 5, 5, 10, 0);
    // T junction: one end lies on the other segment
    queue_pair(0, 0, 0, 10, 0, 5, 0, 5, 8);
    queue_pair(1, 0, 0, 10, 0, 5, 0, 5, 8);
    // near miss by one unit
    queue_pair(0, 0, 0, 10, 0, 5, 1, 5, 10);
    // degenerate first segment sitting on the second
    queue_pair(0, 3, 3, 3, 3, 0, 0, 6, 6);
    queue_pair(1, 3, 3, 3, 3, 0, 0, 6, 6);
    // both degenerate at the same point
    queue_pair(0, 7, -7, 7, -7, 7, -7, 7, -7);
    queue_pair(1, 7, -7, 7, -7, 7, -7, 7, -7);
    // full-range diagonals crossing at the center
    queue_pair(0, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    queue_pair(1, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    // every coordinate at its maximum / minimum
    queue_pair(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_pair(1, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    // far-apart horizontal edges of the coordinate range
    queue_pair(0, -32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    // collinear, touching at the origin, spanning the whole x range
    queue_pair(0, -32768, 0, 0, 0, 0, 0, 32767, 0);
    queue_pair(1, -32768, 0, 0, 0, 0, 0, 32767, 0);

    for (int ph = 0; ph < N_TOL_PHASES; ph++) begin
      if (ph != 0)
        write_tolerance(tol_plan[ph]);
      repeat (PHASE_PAIRS) queue_random_pair();
      drain_requests();
    end

    if (mismatch_count == 0)
      $display("** segment_intersection_test_top: PASSED **");
    else
      $display("** segment_intersection_test_top: FAILED **");
    $finish;
  end

endmodule

FILE: segment_intersection_test_top.f
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_front.sv
rtl/sit_queue.sv
rtl/sit_back.sv
rtl/segment_intersection_test_top.sv
test/tb_segment_intersection_test_top.sv
